@@ hdl/fmad_pkg.sv @@
// ----------------------------------------------------------------------------
// fmad_pkg
// Shared types and constants for the three-axis force smoother.
// ----------------------------------------------------------------------------
package fmad_pkg;

    localparam int AXES = 3;

    // Control word that travels down the pipeline next to each request.
    typedef struct packed {
        logic valid;
        logic cal;
    } ctl_t;

endpackage

@@ hdl/fmad_in_if.sv @@
// ----------------------------------------------------------------------------
// fmad_in_if
// Sample channel: one three-axis force request per valid/ready handshake.
// ----------------------------------------------------------------------------
interface fmad_in_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] force_x;
    logic signed [SAMPLE_WIDTH-1:0] force_y;
    logic signed [SAMPLE_WIDTH-1:0] force_z;

    modport source (output valid, output force_x, output force_y, output force_z,
                    input ready);
    modport sink   (input valid, input force_x, input force_y, input force_z,
                    output ready);
endinterface

@@ hdl/fmad_out_if.sv @@
// ----------------------------------------------------------------------------
// fmad_out_if
// Result channel: filtered three-axis force and the calibration flag.
// ----------------------------------------------------------------------------
interface fmad_out_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [SAMPLE_WIDTH:0] out_x;
    logic signed [SAMPLE_WIDTH:0] out_y;
    logic signed [SAMPLE_WIDTH:0] out_z;
    logic                         calibrated;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output calibrated, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input calibrated, output ready);
endinterface

@@ hdl/force_moving_average_debias.sv @@
// ----------------------------------------------------------------------------
// force_moving_average_debias
// Three-axis moving average with start-up bias removal.
// ----------------------------------------------------------------------------
// Each request on the samples channel carries one signed sample per axis and
// yields exactly one request on the results channel, in order. A result is the
// moving average over the last WINDOW_LEN samples of each axis; the first
// BIAS_LEN averages are summed into a bias and passed out as they are, and
// every later average has the bias mean taken off, with calibrated set.
// One request is taken in every cycle unless the receiver stalls. A request
// passes the running sums, the window divider's quotient register, a delay
// cell and the result register, which takes the bias mean off. The average
// waits one stage before the subtractor so that the registered bias mean
// has settled before the first calibrated average reaches it.
// Reset clears the sample shift line, the running and bias sums and the
// warm-up count, so the window starts out full of zeros.
// When the receiver stalls, the whole pipeline holds and samples.ready falls;
// it rises again in the cycle in which the waiting result is taken.
// ----------------------------------------------------------------------------
module force_moving_average_debias
    import fmad_pkg::*;
#(
    parameter int WINDOW_LEN   = 16,
    parameter int BIAS_LEN     = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    fmad_in_if.sink      samples,
    fmad_out_if.source   results
);

    localparam int S        = SAMPLE_WIDTH;
    localparam int VEC_W    = AXES * S;
    localparam int SUM_W    = S + $clog2(WINDOW_LEN);
    localparam int BSUM_W   = S + $clog2(BIAS_LEN);
    localparam int AVG_LAT  = 1;
    localparam int DLY_LEN  = 1;
    localparam int CTL_LEN  = 1 + AVG_LAT + DLY_LEN;
    localparam int CNT_W    = $clog2(BIAS_LEN + 1);

    logic                     adv;
    logic                     accept;
    logic                     cal_now;
    logic [VEC_W-1:0]         in_vec;
    logic [VEC_W-1:0]         ring_q [0:WINDOW_LEN-1];
    logic [VEC_W-1:0]         dly_q  [0:DLY_LEN-1];
    logic [VEC_W-1:0]         avg_vec;
    logic signed [SUM_W-1:0]  sum_reg  [AXES];
    logic signed [SUM_W-1:0]  sum_next [AXES];
    logic signed [SUM_W-1:0]  quot     [AXES];
    logic signed [BSUM_W-1:0] bias_reg [AXES];
    logic signed [BSUM_W-1:0] bquot    [AXES];
    logic signed [S-1:0]      mean     [AXES];
    logic signed [S-1:0]      dly_avg  [AXES];
    logic signed [S:0]        res_next [AXES];
    logic signed [S:0]        res_reg  [AXES];
    logic [CNT_W-1:0]         cnt_reg;
    ctl_t                     ctl_reg [0:CTL_LEN-1];
    ctl_t                     ctl_tail;
    ctl_t                     ctl_avg;
    logic                     out_valid_reg;
    logic                     cal_reg;

    assign adv           = !out_valid_reg || results.ready;
    assign samples.ready = adv;
    assign accept        = samples.valid && adv;
    assign cal_now       = (cnt_reg == CNT_W'(BIAS_LEN));
    assign in_vec        = {samples.force_z, samples.force_y, samples.force_x};
    assign ctl_avg       = ctl_reg[AVG_LAT];
    assign ctl_tail      = ctl_reg[CTL_LEN-1];

    // The shift line of samples plays the part of the ring buffer: the last
    // cell holds the sample that leaves the window.
    for (genvar i = 0; i < WINDOW_LEN; i++)
    begin : g_ring
        fmad_tap_cell #(.WIDTH(VEC_W)) u_tap (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (accept),
            .d     ((i == 0) ? in_vec : ring_q[(i == 0) ? 0 : i - 1]),
            .q     (ring_q[i])
        );
    end

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            sum_next[a] = sum_reg[a]
                        + SUM_W'($signed(in_vec[a*S +: S]))
                        - SUM_W'($signed(ring_q[WINDOW_LEN-1][a*S +: S]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                sum_reg[a] <= '0;
            end
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                sum_reg[a] <= sum_next[a];
            end
            if (!cal_now)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CTL_LEN; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            ctl_reg[0] <= '{valid: samples.valid, cal: cal_now};
            for (int k = 1; k < CTL_LEN; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    for (genvar a = 0; a < AXES; a++)
    begin : g_axis
        fmad_cdiv #(.IN_W(SUM_W), .DIVISOR(WINDOW_LEN)) u_avg_div (
            .clk  (clk),
            .en   (adv),
            .din  (sum_reg[a]),
            .dout (quot[a])
        );

        // The bias sum stops changing once warm-up is over, so its divider
        // runs freely and settles before the first calibrated average reaches the subtractor.
        fmad_cdiv #(.IN_W(BSUM_W), .DIVISOR(BIAS_LEN)) u_bias_div (
            .clk  (clk),
            .en   (1'b1),
            .din  (bias_reg[a]),
            .dout (bquot[a])
        );

        assign avg_vec[a*S +: S] = quot[a][S-1:0];
        assign mean[a]           = bquot[a][S-1:0];
        assign dly_avg[a]        = $signed(dly_q[DLY_LEN-1][a*S +: S]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                bias_reg[a] <= '0;
            end
        end
        else if (adv && ctl_avg.valid && !ctl_avg.cal)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                bias_reg[a] <= bias_reg[a] + BSUM_W'($signed(avg_vec[a*S +: S]));
            end
        end
    end

    for (genvar j = 0; j < DLY_LEN; j++)
    begin : g_dly
        fmad_tap_cell #(.WIDTH(VEC_W)) u_tap (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .d     ((j == 0) ? avg_vec : dly_q[(j == 0) ? 0 : j - 1]),
            .q     (dly_q[j])
        );
    end

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            if (ctl_tail.cal)
            begin
                res_next[a] = (S + 1)'(dly_avg[a]) - (S + 1)'(mean[a]);
            end
            else
            begin
                res_next[a] = (S + 1)'(dly_avg[a]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ctl_tail.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && ctl_tail.valid)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                res_reg[a] <= res_next[a];
            end
            cal_reg <= ctl_tail.cal;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.out_x      = res_reg[0];
    assign results.out_y      = res_reg[1];
    assign results.out_z      = res_reg[2];
    assign results.calibrated = cal_reg;

endmodule

@@ hdl/fmad_tap_cell.sv @@
// ----------------------------------------------------------------------------
// fmad_tap_cell
// One cell of a shift line: holds a word and takes its neighbour's word.
// ----------------------------------------------------------------------------
module fmad_tap_cell #(
    parameter int WIDTH = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (en)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

@@ hdl/fmad_div_cell.sv @@
// ----------------------------------------------------------------------------
// fmad_div_cell
// Unsigned division of a magnitude by a constant divisor.
// ----------------------------------------------------------------------------
module fmad_div_cell #(
    parameter int WORD_W  = 20,
    parameter int DIVISOR = 16
) (
    input  logic [WORD_W-1:0] mag,
    output logic [WORD_W-1:0] quot
);

    localparam int SHIFT = $clog2(DIVISOR);

    // A power of two is a plain shift. Any other divisor uses a rounded-up
    // reciprocal with SHIFT guard bits, which is exact for every word value.
    if ((DIVISOR & (DIVISOR - 1)) == 0)
    begin : g_shift
        assign quot = mag >> SHIFT;
    end
    else
    begin : g_recip
        localparam int               K     = WORD_W + SHIFT;
        localparam int               MUL_W = WORD_W + 1;
        localparam longint           ONE_K = longint'(1) <<< K;
        localparam logic [MUL_W-1:0] RECIP =
            MUL_W'((ONE_K + longint'(DIVISOR) - 1) / longint'(DIVISOR));

        logic [WORD_W+MUL_W-1:0] prod;

        assign prod = {{MUL_W{1'b0}}, mag} * {{WORD_W{1'b0}}, RECIP};
        assign quot = WORD_W'(prod >> K);
    end

endmodule

@@ hdl/fmad_cdiv.sv @@
// ----------------------------------------------------------------------------
// fmad_cdiv
// Signed division by a constant, truncating toward zero.
// The quotient is registered, updating only while en is high.
// ----------------------------------------------------------------------------
module fmad_cdiv #(
    parameter int IN_W    = 20,
    parameter int DIVISOR = 16
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [IN_W-1:0] din,
    output logic signed [IN_W-1:0] dout
);

    logic                   neg;
    logic [IN_W-1:0]        mag;
    logic [IN_W-1:0]        mag_quot;
    logic signed [IN_W-1:0] quot_next;
    logic signed [IN_W-1:0] quot_reg;

    // The magnitude of the most negative value still fits as an unsigned word.
    assign neg = din[IN_W-1];
    assign mag = neg ? IN_W'(-din) : IN_W'(din);

    fmad_div_cell #(
        .WORD_W  (IN_W),
        .DIVISOR (DIVISOR)
    ) u_cell (
        .mag  (mag),
        .quot (mag_quot)
    );

    assign quot_next = neg ? $signed(IN_W'(-mag_quot)) : $signed(mag_quot);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= quot_next;
        end
    end

    assign dout = quot_reg;

endmodule

@@ hdl/fmad_checker.sv @@
// ----------------------------------------------------------------------------
// fmad_checker
// Port-level checks of the force smoother, bound to the top level.
// ----------------------------------------------------------------------------
module fmad_checker #(
    parameter int BIAS_LEN     = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_WIDTH:0]  out_x,
    input logic [SAMPLE_WIDTH:0]  out_y,
    input logic [SAMPLE_WIDTH:0]  out_z,
    input logic                   calibrated
);

    localparam int CNT_W = $clog2(BIAS_LEN + 1);

    logic             in_acc;
    logic             out_acc;
    logic [15:0]      pending_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 16'(in_acc) - 16'(out_acc);
            if (out_acc && (out_cnt_reg != CNT_W'(BIAS_LEN)))
            begin
                out_cnt_reg <= out_cnt_reg + 1'b1;
            end
        end
    end

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
                                    && $stable(out_z) && $stable(calibrated))
        else $error("result changed while stalled");

    // No result leaves without a request having gone in before it.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pending_reg != 16'd0)
        else $error("result without an outstanding request");

    // Exactly the first BIAS_LEN results are uncalibrated.
    a_cal_point: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> calibrated == (out_cnt_reg == CNT_W'(BIAS_LEN)))
        else $error("calibrated flag at the wrong result");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result offered during reset");

endmodule

bind force_moving_average_debias fmad_checker #(
    .BIAS_LEN     (BIAS_LEN),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_fmad_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_x      (results.out_x),
    .out_y      (results.out_y),
    .out_z      (results.out_z),
    .calibrated (results.calibrated)
);

@@ tb/force_moving_average_debias_tb.sv @@
// ----------------------------------------------------------------------------
// force_moving_average_debias_tb
// Self-checking bench for the three-axis moving average with bias removal.
// ----------------------------------------------------------------------------
// Sample requests are driven from a short directed table, followed by about
// two thousand random requests grouped in segments of corner, small, steady
// and full-scale values. A behavioural predictor updates its own window and
// bias state on every accepted sample request and queues the expected
// result, which the result monitor compares field by field. Both channels
// idle in random bursts, the receiver holds off once for a long stretch and
// the sender once waits for the pipeline to drain.
// ----------------------------------------------------------------------------
module force_moving_average_debias_tb
    import fmad_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_LEN   = 16;
    localparam int BIAS_LEN     = 32;
    localparam int SAMPLE_WIDTH = 16;
    localparam int LATENCY      = 3;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 1975;
    localparam int CALM_ITEMS    = 300;
    localparam int DRAIN_AT      = 1200;
    localparam int HOLD_AT       = 700;
    localparam int LONG_HOLD     = 200;
    localparam int IDLE_LIMIT    = 2000;
    localparam int REPORT_LIMIT  = 10;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH:0] x;
        logic signed [SAMPLE_WIDTH:0] y;
        logic signed [SAMPLE_WIDTH:0] z;
        logic                         cal;
    } force_result_t;

    typedef struct packed {
        sample_t                      fx;
        sample_t                      fy;
        sample_t                      fz;
        logic                         typed;
        logic signed [SAMPLE_WIDTH:0] ex;
        logic signed [SAMPLE_WIDTH:0] ey;
        logic signed [SAMPLE_WIDTH:0] ez;
        logic                         ecal;
    } directed_row_t;

    typedef enum int {
        MODE_UNIFORM,
        MODE_CORNER,
        MODE_SMALL,
        MODE_STEADY,
        MODE_HIGH,
        MODE_LOW
    } sample_mode_e;

    // The first rows start from the cleared window, so their averages are
    // the sum of the samples so far divided by the window length.
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{16'h0000, 16'h0000, 16'h0000, 1'b1, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h8000, 16'h7FFF, 16'h0000, 1'b1, -17'sd2048, 17'sd2047, 17'sd0, 1'b0},
        '{16'h7FFF, 16'h8000, 16'h5555, 1'b1, 17'sd0, 17'sd0, 17'sd1365, 1'b0},
        '{16'h7FFF, 16'h8000, 16'hAAAA, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h7FFF, 16'h8000, 16'h5555, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h7FFF, 16'h8000, 16'hAAAA, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h7FFF, 16'h8000, 16'h5555, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h7FFF, 16'h8000, 16'hAAAA, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h7FFF, 16'h8000, 16'h5555, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h7FFF, 16'h8000, 16'hAAAA, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h7FFF, 16'h8000, 16'h5555, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h7FFF, 16'h8000, 16'hAAAA, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h7FFF, 16'h8000, 16'h5555, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h7FFF, 16'h8000, 16'hAAAA, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h7FFF, 16'h8000, 16'h5555, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h7FFF, 16'h8000, 16'hAAAA, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h7FFF, 16'h8000, 16'h5555, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h7FFF, 16'h8000, 16'h8000, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h0001, 16'h0001, 16'h0001, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h00FF, 16'hFF00, 16'h0FF0, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'hF00F, 16'h0F0F, 16'hF0F0, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h8000, 16'h8000, 16'h8000, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0},
        '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 17'sd0, 17'sd0, 17'sd0, 1'b0}
    };

    logic clk;
    logic rst_n;

    fmad_in_if  #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) samples ();
    fmad_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) results ();

    force_moving_average_debias #(
        .WINDOW_LEN   (WINDOW_LEN),
        .BIAS_LEN     (BIAS_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results)
    );

    // Predictor state: sample history, running sums and the warm-up bias.
    int history [WINDOW_LEN][AXES];
    int window_total [AXES];
    int bias_total [AXES];
    int slot;
    int warmup_seen;

    force_result_t filtered_q [$];

    int  err_count;
    int  sent_count;
    int  taken_count;
    int  calibrated_count;
    bit  calm_tail;
    bit  hold_done;
    bit  drain_done;

    sample_mode_e axis_mode [AXES];
    int           steady_level [AXES];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic force_result_t predict_filtered(input sample_t fx, input sample_t fy,
                                                       input sample_t fz);
        int            fresh [AXES];
        int            avg [AXES];
        force_result_t r;
        bit            cal;

        fresh[0] = fx;
        fresh[1] = fy;
        fresh[2] = fz;
        for (int a = 0; a < AXES; a++)
        begin
            window_total[a] = window_total[a] + fresh[a] - history[slot][a];
            history[slot][a] = fresh[a];
            avg[a] = window_total[a] / WINDOW_LEN;
        end
        slot = (slot + 1 >= WINDOW_LEN) ? 0 : slot + 1;

        cal = (warmup_seen >= BIAS_LEN);
        if (!cal)
        begin
            for (int a = 0; a < AXES; a++)
                bias_total[a] += avg[a];
            warmup_seen++;
        end
        else
        begin
            for (int a = 0; a < AXES; a++)
                avg[a] = avg[a] - bias_total[a] / BIAS_LEN;
        end
        r.x   = avg[0][SAMPLE_WIDTH:0];
        r.y   = avg[1][SAMPLE_WIDTH:0];
        r.z   = avg[2][SAMPLE_WIDTH:0];
        r.cal = cal;
        return r;
    endfunction

    function automatic sample_t draw_sample(input int a);
        int v;

        case (axis_mode[a])
            MODE_CORNER:
            begin
                case ($urandom_range(0, 4))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = -1;
                    3:       v = 1;
                    default: v = 0;
                endcase
            end
            MODE_SMALL:  v = int'($urandom_range(0, 400)) - 200;
            MODE_STEADY: v = steady_level[a] + int'($urandom_range(0, 8)) - 4;
            MODE_HIGH:   v = 32767 - int'($urandom_range(0, 63));
            MODE_LOW:    v = -32768 + int'($urandom_range(0, 63));
            default:     v = int'($urandom());
        endcase
        return v[SAMPLE_WIDTH-1:0];
    endfunction

    task automatic note_error(input string what, input int want, input int got);
        err_count++;
        if (err_count <= REPORT_LIMIT)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // Offers one sample request and holds it until it is taken; the caller's
    // idle percentage decides whether a short gap follows, except in the calm tail.
    task automatic offer_sample(input sample_t fx, input sample_t fy, input sample_t fz,
                                input logic typed, input force_result_t typed_res,
                                input int idle_pct);
        force_result_t predicted;

        samples.valid   <= 1'b1;
        samples.force_x <= fx;
        samples.force_y <= fy;
        samples.force_z <= fz;
        do
            @(posedge clk);
        while (!samples.ready);

        predicted = predict_filtered(fx, fy, fz);
        filtered_q.insert(filtered_q.size(), typed ? typed_res : predicted);
        sent_count++;

        if (!calm_tail && int'($urandom_range(0, 99)) < idle_pct)
        begin
            samples.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    initial
    begin : sender
        force_result_t typed_res;
        int            seg_left;
        int            idle_pct;

        for (int i = 0; i < WINDOW_LEN; i++)
            for (int a = 0; a < AXES; a++)
                history[i][a] = 0;
        for (int a = 0; a < AXES; a++)
        begin
            window_total[a] = 0;
            bias_total[a]   = 0;
        end
        slot        = 0;
        warmup_seen = 0;
        err_count   = 0;
        sent_count  = 0;
        calm_tail   = 1'b0;
        drain_done  = 1'b0;
        seg_left    = 0;
        idle_pct    = 0;

        samples.valid   <= 1'b0;
        samples.force_x <= '0;
        samples.force_y <= '0;
        samples.force_z <= '0;
        do
            @(posedge clk);
        while (!rst_n);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            typed_res.x   = DIRECTED[r].ex;
            typed_res.y   = DIRECTED[r].ey;
            typed_res.z   = DIRECTED[r].ez;
            typed_res.cal = DIRECTED[r].ecal;
            offer_sample(DIRECTED[r].fx, DIRECTED[r].fy, DIRECTED[r].fz,
                         DIRECTED[r].typed, typed_res, 20);
        end

        typed_res = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(8, 64);
                for (int a = 0; a < AXES; a++)
                begin
                    axis_mode[a]    = sample_mode_e'($urandom_range(0, 5));
                    steady_level[a] = int'($urandom_range(0, 60000)) - 30000;
                end
            end
            seg_left--;

            // Gap density changes now and then, with some stretches free of gaps.
            if (n % 128 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 35;
                endcase
            end
            calm_tail = (n >= RANDOM_ITEMS - CALM_ITEMS);

            // Once in the run the sender waits for the pipeline to empty.
            if (n == DRAIN_AT)
            begin
                samples.valid <= 1'b0;
                do
                    @(posedge clk);
                while (filtered_q.size() != 0);
                drain_done = 1'b1;
            end

            offer_sample(draw_sample(0), draw_sample(1), draw_sample(2), 1'b0, typed_res,
                         idle_pct);
        end
        samples.valid <= 1'b0;

        while (filtered_q.size() != 0)
            @(posedge clk);
        repeat (2*LATENCY) @(posedge clk);

        if (filtered_q.size() != 0)
            note_error("results still outstanding", 0, filtered_q.size());

        $display("Covered %0d sample requests (%0d directed), %0d results, %0d calibrated.",
                 sent_count, DIRECTED_ROWS, taken_count, calibrated_count);
        $display("Long receiver hold-off: %0d, drain pause: %0d.", hold_done, drain_done);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : receiver
        int stall_left;
        int stall_pct;
        int period_left;

        stall_left  = 0;
        stall_pct   = 0;
        period_left = 0;
        hold_done   = 1'b0;
        results.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);

        forever
        begin
            if (period_left == 0)
            begin
                period_left = 150;
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    default: stall_pct = 30;
                endcase
            end
            period_left--;

            if (!hold_done && sent_count >= HOLD_AT)
            begin
                // Long hold-off so that the pipeline fills and stalls the input.
                results.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                results.ready <= 1'b0;
                stall_left--;
            end
            else if (!calm_tail && int'($urandom_range(0, 99)) < stall_pct)
            begin
                results.ready <= 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end
            else
                results.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        force_result_t want;

        if (rst_n && results.valid && results.ready)
        begin
            taken_count++;
            if (results.calibrated)
                calibrated_count++;
            if (filtered_q.size() == 0)
                note_error("unexpected result, queue empty", 0, 1);
            else
            begin
                want = filtered_q.pop_front();
                if (results.out_x !== want.x)
                    note_error("out_x", want.x, results.out_x);
                if (results.out_y !== want.y)
                    note_error("out_y", want.y, results.out_y);
                if (results.out_z !== want.z)
                    note_error("out_z", want.z, results.out_z);
                if (results.calibrated !== want.cal)
                    note_error("calibrated", want.cal, results.calibrated);
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;

        quiet_cycles     = 0;
        taken_count      = 0;
        calibrated_count = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((samples.valid && samples.ready) || (results.valid && results.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no request moved for %0d cycles.", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
hdl/fmad_pkg.sv
hdl/fmad_in_if.sv
hdl/fmad_out_if.sv
hdl/fmad_tap_cell.sv
hdl/fmad_div_cell.sv
hdl/fmad_cdiv.sv
hdl/force_moving_average_debias.sv
hdl/fmad_checker.sv
tb/force_moving_average_debias_tb.sv
